// ----- rtl/wds_pkg.sv -----
// Shared types, constants and the control program of the weighted discrete sampler.
// Used by wds_seq and weighted_discrete_sampler_top; depends on nothing else.
package wds_pkg;

    // Field widths and the default table depth.
    localparam int VALUE_W             = 32;
    localparam int WEIGHT_W            = 16;
    localparam int DRAW_W              = 14;
    localparam int TOTAL_W             = 24;
    localparam int STATUS_W            = 2;
    localparam int TABLE_DEPTH_DEFAULT = 256;

    // Scale of the draw: a draw r stands for r / 10000.
    localparam logic [DRAW_W-1:0] DRAW_SCALE = 14'd10000;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

    // Request kinds carried on the input tuser.
    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // Program addresses.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] S_IDLE   = 4'd0;
    localparam logic [STEP_W-1:0] S_APPEND = 4'd1;
    localparam logic [STEP_W-1:0] S_INIT   = 4'd2;
    localparam logic [STEP_W-1:0] S_READ   = 4'd3;
    localparam logic [STEP_W-1:0] S_ACC    = 4'd4;
    localparam logic [STEP_W-1:0] S_MUL    = 4'd5;
    localparam logic [STEP_W-1:0] S_CMP    = 4'd6;
    localparam logic [STEP_W-1:0] S_MISS   = 4'd7;
    localparam logic [STEP_W-1:0] S_HIT    = 4'd8;
    localparam logic [STEP_W-1:0] S_EMIT   = 4'd9;

    // Datapath action of one step.
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_APPEND,
        ACT_INIT,
        ACT_READ,
        ACT_ACC,
        ACT_MUL,
        ACT_MISS,
        ACT_HIT,
        ACT_EMIT
    } act_t;

    // How the step counter moves on.
    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_DISPATCH,
        C_EMPTY,
        C_SCAN,
        C_EMIT
    } cond_t;

    // One control word of the program.
    typedef struct packed {
        logic              ready;
        act_t              act;
        cond_t             cond;
        logic [STEP_W-1:0] target;
        logic [STEP_W-1:0] alt;
    } ctl_t;

    // Datapath conditions seen by the sequencer.
    typedef struct packed {
        logic accept;
        logic func;
        logic empty;
        logic hit;
        logic more;
        logic out_free;
    } flags_t;

    // The control program. A sample scans one entry every four steps.
    function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
        ctl_t cw;
        cw = '{ready: 1'b0, act: ACT_NONE, cond: C_JUMP, target: S_IDLE, alt: S_IDLE};
        case (step)
            S_IDLE:   cw = '{1'b1, ACT_NONE,   C_DISPATCH, S_APPEND, S_INIT};
            S_APPEND: cw = '{1'b0, ACT_APPEND, C_JUMP,     S_EMIT,   S_IDLE};
            S_INIT:   cw = '{1'b0, ACT_INIT,   C_EMPTY,    S_MISS,   S_IDLE};
            S_READ:   cw = '{1'b0, ACT_READ,   C_NEXT,     S_IDLE,   S_IDLE};
            S_ACC:    cw = '{1'b0, ACT_ACC,    C_NEXT,     S_IDLE,   S_IDLE};
            S_MUL:    cw = '{1'b0, ACT_MUL,    C_NEXT,     S_IDLE,   S_IDLE};
            S_CMP:    cw = '{1'b0, ACT_NONE,   C_SCAN,     S_HIT,    S_READ};
            S_MISS:   cw = '{1'b0, ACT_MISS,   C_JUMP,     S_EMIT,   S_IDLE};
            S_HIT:    cw = '{1'b0, ACT_HIT,    C_NEXT,     S_IDLE,   S_IDLE};
            S_EMIT:   cw = '{1'b0, ACT_EMIT,   C_EMIT,     S_IDLE,   S_IDLE};
            default:  cw = '{1'b0, ACT_NONE,   C_JUMP,     S_IDLE,   S_IDLE};
        endcase
        return cw;
    endfunction

endpackage

// ----- rtl/wds_seq.sv -----
// Step counter and program table of the weighted discrete sampler.
// Depends on wds_pkg for the control word, the condition flags and the program.
module wds_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  wds_pkg::flags_t flags,
    output wds_pkg::ctl_t   cw
);

    logic [wds_pkg::STEP_W-1:0] step_reg;
    logic [wds_pkg::STEP_W-1:0] step_next;

    // Current control word straight from the program table.
    assign cw = wds_pkg::ucode(step_reg);

    // Next step: fall through, jump, or branch on a datapath condition.
    always_comb begin
        case (cw.cond)
            wds_pkg::C_NEXT:     step_next = step_reg + 1'b1;
            wds_pkg::C_JUMP:     step_next = cw.target;
            wds_pkg::C_DISPATCH: begin
                if (flags.accept) begin
                    step_next = (flags.func == wds_pkg::FUNC_SAMPLE) ? cw.alt : cw.target;
                end else begin
                    step_next = step_reg;
                end
            end
            wds_pkg::C_EMPTY:    step_next = flags.empty ? cw.target : step_reg + 1'b1;
            wds_pkg::C_SCAN: begin
                if (flags.hit) begin
                    step_next = cw.target;
                end else if (flags.more) begin
                    step_next = cw.alt;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            wds_pkg::C_EMIT:     step_next = flags.out_free ? cw.target : step_reg;
            default:             step_next = wds_pkg::S_IDLE;
        endcase
    end

    // Step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= wds_pkg::S_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

// ----- rtl/weighted_discrete_sampler_top.sv -----
// Top level of the weighted discrete sampler: table memories, scan datapath and stream ports.
// Depends on wds_pkg and on wds_seq, which sequences the datapath.

// Each request gives exactly one result. An append (tuser 0) stores a value and weight in
// the next free slot and adds the weight to a saturating 24-bit total; when the table is
// full it is dropped with status 1. A sample (tuser 1) scans the entries in order and
// returns the value of the first one whose cumulative weight times 10000 exceeds total
// times the draw, or status 2 and zero if none does. An append passes from its append step,
// which registers the result, to the emit step, which waits until the output register is free.
// A sample scans each entry in a four-step loop of read, accumulate, multiply and compare
// around the single registered read port and the scaling multiplier, then registers its result
// and moves to the emit step. A new request is taken while the previous result still waits on the output.
module weighted_discrete_sampler_top #(
    parameter int TABLE_DEPTH = wds_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // entry_value[31:0], entry_weight[47:32],
                                   // random_draw[61:48], zero[63:62]
    input  logic        s_tuser,   // func[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // sampled_value[31:0]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CUM_W  = wds_pkg::WEIGHT_W + CNT_W;
    localparam int PROD_W = CUM_W + wds_pkg::DRAW_W;
    localparam int TGT_W  = wds_pkg::TOTAL_W + wds_pkg::DRAW_W;
    localparam int CMP_W  = (PROD_W > TGT_W) ? PROD_W : TGT_W;

    wds_pkg::ctl_t   cw;
    wds_pkg::flags_t flags;

    logic [wds_pkg::VALUE_W-1:0]  value_mem  [TABLE_DEPTH];
    logic [wds_pkg::WEIGHT_W-1:0] weight_mem [TABLE_DEPTH];

    logic [wds_pkg::VALUE_W-1:0]  in_value_reg;
    logic [wds_pkg::WEIGHT_W-1:0] in_weight_reg;
    logic [wds_pkg::DRAW_W-1:0]   in_draw_reg;

    logic [CNT_W-1:0]             count_reg;
    logic [wds_pkg::TOTAL_W-1:0]  total_reg;
    logic [wds_pkg::TOTAL_W:0]    total_sum;
    logic                         full;

    logic [CNT_W-1:0]             k_reg;
    logic [CUM_W-1:0]             cum_reg;
    logic [CMP_W-1:0]             prod_reg;
    logic [CMP_W-1:0]             target_reg;
    logic [wds_pkg::VALUE_W-1:0]  value_rd_reg;
    logic [wds_pkg::WEIGHT_W-1:0] weight_rd_reg;

    logic [wds_pkg::VALUE_W-1:0]  res_value_reg;
    logic [wds_pkg::STATUS_W-1:0] res_status_reg;

    logic                         m_tvalid_reg;
    logic [wds_pkg::VALUE_W-1:0]  m_value_reg;
    logic [wds_pkg::STATUS_W-1:0] m_status_reg;

    // Sequencer.
    wds_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .cw      (cw)
    );

    assign s_tready = cw.ready;
    assign full     = (count_reg == CNT_W'(TABLE_DEPTH));
    assign total_sum = {1'b0, total_reg} + (wds_pkg::TOTAL_W + 1)'(in_weight_reg);

    // Conditions handed to the sequencer.
    always_comb begin
        flags.accept   = s_tvalid && s_tready;
        flags.func     = s_tuser;
        flags.empty    = (count_reg == '0);
        flags.hit      = (prod_reg > target_reg);
        flags.more     = (k_reg < count_reg);
        flags.out_free = !m_tvalid_reg || m_tready;
    end

    // Request payload, captured when a request is taken.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_value_reg  <= s_tdata[31:0];
            in_weight_reg <= s_tdata[47:32];
            in_draw_reg   <= s_tdata[61:48];
        end
    end

    // Table memories: one write port at the fill count, one registered read port at the scan index.
    always_ff @(posedge aclk) begin
        if (cw.act == wds_pkg::ACT_APPEND && !full) begin
            value_mem[count_reg[IDX_W-1:0]]  <= in_value_reg;
            weight_mem[count_reg[IDX_W-1:0]] <= in_weight_reg;
        end
        if (cw.act == wds_pkg::ACT_READ) begin
            value_rd_reg  <= value_mem[k_reg[IDX_W-1:0]];
            weight_rd_reg <= weight_mem[k_reg[IDX_W-1:0]];
        end
    end

    // Fill count and saturating weight total.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            total_reg <= '0;
        end else if (cw.act == wds_pkg::ACT_APPEND && !full) begin
            count_reg <= count_reg + 1'b1;
            total_reg <= total_sum[wds_pkg::TOTAL_W] ? wds_pkg::TOTAL_MAX
                                                     : total_sum[wds_pkg::TOTAL_W-1:0];
        end
    end

    // Scan index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= '0;
        end else if (cw.act == wds_pkg::ACT_INIT) begin
            k_reg <= '0;
        end else if (cw.act == wds_pkg::ACT_READ) begin
            k_reg <= k_reg + 1'b1;
        end
    end

    // Scan arithmetic: threshold, running sum and its scaled copy.
    always_ff @(posedge aclk) begin
        case (cw.act)
            wds_pkg::ACT_INIT: begin
                cum_reg    <= '0;
                target_reg <= CMP_W'(total_reg) * CMP_W'(in_draw_reg);
            end
            wds_pkg::ACT_ACC: begin
                cum_reg <= cum_reg + CUM_W'(weight_rd_reg);
            end
            wds_pkg::ACT_MUL: begin
                prod_reg <= CMP_W'(cum_reg) * CMP_W'(wds_pkg::DRAW_SCALE);
            end
            default: begin
            end
        endcase
    end

    // Result of the request in progress.
    always_ff @(posedge aclk) begin
        case (cw.act)
            wds_pkg::ACT_APPEND: begin
                res_value_reg  <= '0;
                res_status_reg <= full ? wds_pkg::ST_FULL : wds_pkg::ST_OK;
            end
            wds_pkg::ACT_MISS: begin
                res_value_reg  <= '0;
                res_status_reg <= wds_pkg::ST_NONE;
            end
            wds_pkg::ACT_HIT: begin
                res_value_reg  <= value_rd_reg;
                res_status_reg <= wds_pkg::ST_OK;
            end
            default: begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cw.act == wds_pkg::ACT_EMIT && flags.out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cw.act == wds_pkg::ACT_EMIT && flags.out_free) begin
            m_value_reg  <= res_value_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_status_reg;

`ifndef SYNTHESIS
    // The fill count never passes the table depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    // The scan never walks past the stored entries.
    assert property (@(posedge aclk) disable iff (!aresetn)
        k_reg <= count_reg)
        else $error("scan index beyond fill count");

    // An empty table has a zero total.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (total_reg == '0))
        else $error("nonzero total on empty table");

    // A result appears on the output only from the emit step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(cw.act == wds_pkg::ACT_EMIT))
        else $error("output loaded outside emit step");

    // A selected entry always reports success.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cw.act == wds_pkg::ACT_HIT) |=> (res_status_reg == wds_pkg::ST_OK))
        else $error("hit without ok status");
`endif

endmodule
